@@ src/text_console_cell_writer_unit_defines.svh @@
// Assertion macros for the text console cell writer.
// Included by the modules that check their own logic.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TCCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/tccw_pkg.sv @@
// Shared types and constants of the text console cell writer.
// No dependencies.
package tccw_pkg;
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam logic [7:0] NL_CODE    = 8'd10;
    localparam logic [7:0] BLANK_CODE = 8'd8;
    localparam logic [7:0] SPACE_CODE = 8'd32;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_BKSP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    typedef logic [CELL_W-1:0] t_addr;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       character;
        logic             use_position;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [7:0]       attribute;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attrib;
        logic             scrolled;
    } t_out;

    typedef enum logic [2:0] {
        OP_PUT_CHAR,
        OP_PUT_NL,
        OP_PUT_BLANK,
        OP_BKSP,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             use_pos;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [7:0]       attr;
    } t_cmd;

    function automatic t_addr cell_addr(input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row);
        return t_addr'(row) * t_addr'(COLUMNS) + t_addr'(col);
    endfunction
endpackage

@@ src/tccw_front.sv @@
// Input stage: accepts items, saturates positions, resolves attributes.
// Holds the default attribute register. Depends on tccw_pkg.
module tccw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tccw_pkg::t_in i_in_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data,
    output logic [7:0]    o_default_attrib,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output tccw_pkg::t_cmd o_cmd
);
    import tccw_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    logic [7:0] r_default_attrib;
    t_cmd       w_cmd;

    assign o_in_ready       = !r_valid || i_cmd_ready;
    assign o_cfg_ready      = 1'b1;
    assign o_default_attrib = r_default_attrib;
    assign o_cmd_valid      = r_valid;
    assign o_cmd            = r_cmd;

    always_comb begin
        w_cmd.use_pos = i_in_data.use_position;
        w_cmd.col     = (i_in_data.column >= COL_W'(COLUMNS)) ?
                        COL_W'(COLUMNS - 1) : i_in_data.column;
        w_cmd.row     = (i_in_data.row >= ROW_W'(ROWS)) ?
                        ROW_W'(ROWS - 1) : i_in_data.row;
        w_cmd.ch      = i_in_data.character;
        w_cmd.attr    = (i_in_data.attribute == 8'd0) ? r_default_attrib
                                                      : i_in_data.attribute;
        unique case (i_in_data.action)
            ACT_PUT: begin
                if (i_in_data.character == NL_CODE) begin
                    w_cmd.op = OP_PUT_NL;
                end else if (i_in_data.character == BLANK_CODE) begin
                    w_cmd.op = OP_PUT_BLANK;
                end else begin
                    w_cmd.op = OP_PUT_CHAR;
                end
            end
            ACT_BKSP:  w_cmd.op = OP_BKSP;
            ACT_CLEAR: w_cmd.op = OP_CLEAR;
            default:   w_cmd.op = OP_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid          <= 1'b0;
            r_default_attrib <= 8'd7;
        end else begin
            if (i_cfg_valid) begin
                r_default_attrib <= i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                r_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_cmd <= w_cmd;
        end
    end
endmodule

@@ src/tccw_queue.sv @@
// Two-entry command queue between front and back.
// Depends on tccw_pkg.
module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tccw_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tccw_pkg::t_cmd o_pop_data
);
    import tccw_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end
endmodule

@@ src/tccw_back.sv @@
// Executor: cell memory, cursor, scroll/clear/reset sweeps and result register.
// Depends on tccw_pkg and the assertion macro header.
`include "text_console_cell_writer_unit_defines.svh"
module tccw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_default_attrib,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  tccw_pkg::t_cmd i_cmd,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tccw_pkg::t_out o_out_data
);
    import tccw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_RD, S_SCR_RD, S_SCR_WR, S_ZERO, S_CLR
    } t_state;

    localparam t_addr LAST_CELL = t_addr'(CELLS - 1);
    localparam t_addr LAST_MOVE = t_addr'(CELLS - COLUMNS - 1);
    localparam t_addr LAST_ROW0 = t_addr'(CELLS - COLUMNS);

    t_state           r_state;
    t_addr            r_cnt;
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_cur_row;
    logic             r_out_valid;
    t_out             r_out;
    logic [15:0]      r_mem [CELLS];
    logic [15:0]      r_rdata;

    logic             w_pop;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_bk_col;
    logic [ROW_W-1:0] w_bk_row;
    logic             w_we;
    t_addr            w_waddr;
    logic [15:0]      w_wdata;
    t_addr            w_raddr;

    assign o_cmd_ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_pop       = o_cmd_ready && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_col       = i_cmd.use_pos ? i_cmd.col : r_cur_col;
    assign w_row       = i_cmd.use_pos ? i_cmd.row : r_cur_row;

    always_comb begin
        w_bk_col = r_cur_col;
        w_bk_row = r_cur_row;
        if (r_cur_col != '0) begin
            w_bk_col = r_cur_col - COL_W'(1);
        end else if (r_cur_row != '0) begin
            w_bk_col = COL_W'(COLUMNS - 1);
            w_bk_row = r_cur_row - ROW_W'(1);
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = 16'd0;
        w_raddr = cell_addr(w_col, w_row);
        unique case (r_state)
            S_INIT, S_ZERO: w_we = 1'b1;
            S_CLR: begin
                w_we    = 1'b1;
                w_wdata = {i_default_attrib, SPACE_CODE};
            end
            S_SCR_RD: w_raddr = r_cnt + t_addr'(COLUMNS);
            S_SCR_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
            end
            S_IDLE: begin
                if (w_pop) begin
                    w_waddr = cell_addr(w_col, w_row);
                    unique case (i_cmd.op)
                        OP_PUT_CHAR: begin
                            w_we    = 1'b1;
                            w_wdata = {i_cmd.attr, i_cmd.ch};
                        end
                        OP_PUT_BLANK: begin
                            w_we    = 1'b1;
                            w_wdata = {i_cmd.attr, SPACE_CODE};
                        end
                        OP_BKSP: begin
                            w_we    = 1'b1;
                            w_waddr = cell_addr(w_bk_col, w_bk_row);
                            w_wdata = {i_default_attrib, SPACE_CODE};
                        end
                        default: w_we = 1'b0;
                    endcase
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + t_addr'(1);
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_pop) begin
                        r_out.cell_char   <= 8'd0;
                        r_out.cell_attrib <= 8'd0;
                        r_out.scrolled    <= 1'b0;
                        r_out.cursor_column <= r_cur_col;
                        r_out.cursor_row    <= r_cur_row;
                        r_out_valid         <= 1'b1;
                        priority case (i_cmd.op)
                            OP_PUT_CHAR, OP_PUT_NL: begin
                                if (i_cmd.op == OP_PUT_CHAR &&
                                    w_col != COL_W'(COLUMNS - 1)) begin
                                    r_cur_col           <= w_col + COL_W'(1);
                                    r_cur_row           <= w_row;
                                    r_out.cursor_column <= w_col + COL_W'(1);
                                    r_out.cursor_row    <= w_row;
                                end else if (w_row == ROW_W'(ROWS - 1)) begin
                                    r_cur_col           <= '0;
                                    r_cur_row           <= w_row;
                                    r_out.cursor_column <= '0;
                                    r_out.cursor_row    <= w_row;
                                    r_out.scrolled      <= 1'b1;
                                    r_out_valid         <= 1'b0;
                                    r_cnt               <= '0;
                                    r_state             <= S_SCR_RD;
                                end else begin
                                    r_cur_col           <= '0;
                                    r_cur_row           <= w_row + ROW_W'(1);
                                    r_out.cursor_column <= '0;
                                    r_out.cursor_row    <= w_row + ROW_W'(1);
                                end
                            end
                            OP_PUT_BLANK: begin
                                r_cur_col           <= w_col;
                                r_cur_row           <= w_row;
                                r_out.cursor_column <= w_col;
                                r_out.cursor_row    <= w_row;
                            end
                            OP_BKSP: begin
                                r_cur_col           <= w_bk_col;
                                r_cur_row           <= w_bk_row;
                                r_out.cursor_column <= w_bk_col;
                                r_out.cursor_row    <= w_bk_row;
                            end
                            OP_CLEAR: begin
                                r_cur_col           <= '0;
                                r_cur_row           <= '0;
                                r_out.cursor_column <= '0;
                                r_out.cursor_row    <= '0;
                                r_out_valid         <= 1'b0;
                                r_cnt               <= '0;
                                r_state             <= S_CLR;
                            end
                            default: begin
                                r_out_valid <= 1'b0;
                                r_state     <= S_RD;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_out.cell_char   <= r_rdata[7:0];
                    r_out.cell_attrib <= r_rdata[15:8];
                    r_out_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_SCR_RD: r_state <= S_SCR_WR;
                S_SCR_WR: begin
                    r_cnt <= r_cnt + t_addr'(1);
                    r_state <= (r_cnt == LAST_MOVE) ? S_ZERO : S_SCR_RD;
                end
                S_ZERO, S_CLR: begin
                    r_cnt <= r_cnt + t_addr'(1);
                    if (r_cnt == LAST_CELL) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TCCW_ASSERT_IMPL(a_cursor_col, i_clk, i_rst_n, 1'b1, r_cur_col < COL_W'(COLUMNS))
    `TCCW_ASSERT_IMPL(a_sweep_quiet, i_clk, i_rst_n, r_state == S_SCR_RD, !r_out_valid)
    `TCCW_ASSERT_IMPL(a_scroll_row, i_clk, i_rst_n, r_out_valid && r_out.scrolled, r_out.cursor_row == ROW_W'(ROWS - 1))
    `TCCW_ASSERT_NEXT(a_zero_start, i_clk, i_rst_n, r_state == S_SCR_WR && r_cnt == LAST_MOVE, r_cnt == LAST_ROW0)
endmodule

@@ src/text_console_cell_writer_unit.sv @@
// Text console cell writer: 80x25 cell memory with cursor, scroll and clear.
// Put, blank and backspace results are registered on acceptance; a read adds the S_RD state; clear sweeps all cells.
// Scroll put: each moved cell is read, then written one row up, on the single read port.
// The executor takes a new command only when idle with no result pending; sweeps stall input.
// Reset: synchronous; a pass over all cells zeroes the cell memory before the executor takes commands.
module text_console_cell_writer_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tccw_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tccw_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import tccw_pkg::*;

    logic       w_f_valid;
    logic       w_f_ready;
    t_cmd       w_f_cmd;
    logic       w_q_valid;
    logic       w_q_ready;
    t_cmd       w_q_cmd;
    logic [7:0] w_default_attrib;

    tccw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_data        (i_in_data),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_default_attrib (w_default_attrib),
        .o_cmd_valid      (w_f_valid),
        .i_cmd_ready      (w_f_ready),
        .o_cmd            (w_f_cmd)
    );

    tccw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_cmd)
    );

    tccw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_default_attrib (w_default_attrib),
        .i_cmd_valid      (w_q_valid),
        .o_cmd_ready      (w_q_ready),
        .i_cmd            (w_q_cmd),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_data       (o_out_data)
    );
endmodule
